@@ hw/rtl/itors_pkg.sv @@
// Package for the integer to radix string block: item types, the widths that
// follow from the value width, and the microcode program with its field codes.
// Depends on nothing; used by integer_to_radix_string.
package itors_pkg;

  localparam int unsigned VALUE_WIDTH = 32;
  localparam int unsigned RADIX_WIDTH = 6;
  localparam int unsigned CHAR_WIDTH  = 8;

  // Radix 2 gives the longest string: one digit per value bit.
  localparam int unsigned MAX_DIGITS = VALUE_WIDTH;
  localparam int unsigned DIG_IDX_W  = $clog2(MAX_DIGITS);
  localparam int unsigned DIG_CNT_W  = $clog2(MAX_DIGITS + 1);
  localparam int unsigned BIT_CNT_W  = $clog2(VALUE_WIDTH);

  localparam logic [RADIX_WIDTH-1:0] RADIX_MIN     = RADIX_WIDTH'(2);
  localparam logic [RADIX_WIDTH-1:0] RADIX_MAX     = RADIX_WIDTH'(36);
  localparam logic [RADIX_WIDTH-1:0] RADIX_DECIMAL = RADIX_WIDTH'(10);
  localparam logic [CHAR_WIDTH-1:0]  CHAR_MINUS    = 8'h2D;
  localparam logic [CHAR_WIDTH-1:0]  CHAR_ZERO     = 8'h30;
  // Letter digits start at ten, so 'A' minus ten.
  localparam logic [CHAR_WIDTH-1:0]  CHAR_ALPHA    = 8'h37;

  typedef struct packed {
    logic signed [VALUE_WIDTH-1:0] value;
    logic [RADIX_WIDTH-1:0]        radix;
  } in_item_t;

  typedef struct packed {
    logic [CHAR_WIDTH-1:0] character;
    logic                  last;
  } out_item_t;

  localparam int unsigned PC_W = 3;
  typedef logic [PC_W-1:0] pc_t;

  typedef enum logic [2:0] {
    OP_NOP,
    OP_LOAD,
    OP_CLR_REM,
    OP_DIV_BIT,
    OP_STORE,
    OP_SIGN,
    OP_READ,
    OP_EMIT
  } op_e;

  typedef enum logic [2:0] {
    C_ALWAYS,
    C_NEVER,
    C_IN_VALID,
    C_OUT_FREE,
    C_BIT_MORE,
    C_QUOT_NZ,
    C_NDIG_NZ
  } cond_e;

  // A step waits until wait_cond holds, then performs op, then goes to target
  // if br_cond holds and to the following step otherwise.
  typedef struct packed {
    cond_e wait_cond;
    op_e   op;
    cond_e br_cond;
    pc_t   target;
  } uword_t;

  localparam pc_t PC_IDLE     = 3'd0;
  localparam pc_t PC_DIV_INIT = 3'd1;
  localparam pc_t PC_DIV_BIT  = 3'd2;
  localparam pc_t PC_STORE    = 3'd3;
  localparam pc_t PC_SIGN     = 3'd4;
  localparam pc_t PC_READ     = 3'd5;
  localparam pc_t PC_EMIT     = 3'd6;
  localparam pc_t PC_RETURN   = 3'd7;

  function automatic uword_t ucode_rom(pc_t pc);
    uword_t w;
    unique case (pc)
      PC_IDLE:     w = '{C_IN_VALID, OP_LOAD,    C_NEVER,    PC_IDLE};
      PC_DIV_INIT: w = '{C_ALWAYS,   OP_CLR_REM, C_NEVER,    PC_IDLE};
      PC_DIV_BIT:  w = '{C_ALWAYS,   OP_DIV_BIT, C_BIT_MORE, PC_DIV_BIT};
      PC_STORE:    w = '{C_ALWAYS,   OP_STORE,   C_QUOT_NZ,  PC_DIV_INIT};
      PC_SIGN:     w = '{C_OUT_FREE, OP_SIGN,    C_NEVER,    PC_IDLE};
      PC_READ:     w = '{C_ALWAYS,   OP_READ,    C_NEVER,    PC_IDLE};
      PC_EMIT:     w = '{C_OUT_FREE, OP_EMIT,    C_NDIG_NZ,  PC_READ};
      PC_RETURN:   w = '{C_ALWAYS,   OP_NOP,     C_ALWAYS,   PC_IDLE};
      default:     w = '{C_ALWAYS,   OP_NOP,     C_ALWAYS,   PC_IDLE};
    endcase
    return w;
  endfunction

  function automatic logic [CHAR_WIDTH-1:0] digit_char(logic [RADIX_WIDTH-1:0] d);
    logic [CHAR_WIDTH-1:0] c;
    if (d < RADIX_WIDTH'(10)) begin
      c = CHAR_ZERO + CHAR_WIDTH'(d);
    end else begin
      c = CHAR_ALPHA + CHAR_WIDTH'(d);
    end
    return c;
  endfunction

endpackage

@@ hw/rtl/integer_to_radix_string.sv @@
// Top level of the integer to radix string block: a microcoded sequencer over
// a bit-serial divider and a digit memory. Depends on itors_pkg.
//
// Usage: an item on the input channel carries a signed value and a radix; the
// block answers with the ASCII characters of the number, most significant
// digit first, one output item per character, with last set on the final one.
// Radix 10 writes a negative value as a minus sign and its magnitude; other
// radices read the value as an unsigned pattern. Radices outside 2..36 are
// clamped to the nearer end.
// Both channels use valid and stall. The input is stalled from the cycle after
// an item is taken until the sequencer leaves its return step, which follows the
// placing of the final character in the output register, so one item is in
// work at a time. Each digit comes from the restoring divider, which yields one
// quotient bit per cycle; all digits are divided out before the first is sent.
// A stalled receiver holds the current character; the sequencer waits at that
// step without losing anything. Reset returns the sequencer to its idle step
// and empties the output register; the digit memory is not cleared.
module integer_to_radix_string (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  itors_pkg::in_item_t  in_item_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output itors_pkg::out_item_t out_item_o
);
  import itors_pkg::*;

  pc_t                    pc_q, pc_d;
  logic [VALUE_WIDTH-1:0] quot_q, quot_d;
  logic [RADIX_WIDTH-1:0] rem_q, rem_d;
  logic [RADIX_WIDTH-1:0] radix_q, radix_d;
  logic [BIT_CNT_W-1:0]   bit_cnt_q, bit_cnt_d;
  logic [DIG_CNT_W-1:0]   ndig_q, ndig_d;
  logic                   neg_q, neg_d;
  logic                   out_valid_q, out_valid_d;
  out_item_t              out_item_q, out_item_d;

  logic [RADIX_WIDTH-1:0] dig_mem [MAX_DIGITS];
  logic [RADIX_WIDTH-1:0] rd_digit_q;
  logic                   mem_we, mem_re;
  logic [DIG_IDX_W-1:0]   mem_waddr, mem_raddr;

  uword_t                 uw;
  logic                   wait_ok, br_ok, out_free;
  logic [RADIX_WIDTH-1:0] radix_clamped;
  logic                   load_neg;
  logic [RADIX_WIDTH:0]   trial;
  logic [DIG_CNT_W-1:0]   ndig_dec;

  assign uw       = ucode_rom(pc_q);
  assign out_free = !out_valid_q || !out_stall_i;
  assign ndig_dec = ndig_q - DIG_CNT_W'(1);

  function automatic logic cond_eval(cond_e c, logic in_v, logic o_free, logic bit_more,
                                     logic quot_nz, logic ndig_nz);
    logic r;
    unique case (c)
      C_ALWAYS:   r = 1'b1;
      C_NEVER:    r = 1'b0;
      C_IN_VALID: r = in_v;
      C_OUT_FREE: r = o_free;
      C_BIT_MORE: r = bit_more;
      C_QUOT_NZ:  r = quot_nz;
      C_NDIG_NZ:  r = ndig_nz;
      default:    r = 1'b0;
    endcase
    return r;
  endfunction

  // Branch conditions look at the registers before the step's own update.
  assign wait_ok = cond_eval(uw.wait_cond, in_valid_i, out_free,
                             bit_cnt_q != BIT_CNT_W'(VALUE_WIDTH - 1),
                             quot_q != '0, ndig_q != '0);
  assign br_ok   = cond_eval(uw.br_cond, in_valid_i, out_free,
                             bit_cnt_q != BIT_CNT_W'(VALUE_WIDTH - 1),
                             quot_q != '0, ndig_q != '0);

  assign in_stall_o = (pc_q != PC_IDLE);

  always_comb begin
    if (in_item_i.radix < RADIX_MIN) begin
      radix_clamped = RADIX_MIN;
    end else if (in_item_i.radix > RADIX_MAX) begin
      radix_clamped = RADIX_MAX;
    end else begin
      radix_clamped = in_item_i.radix;
    end
    load_neg = (radix_clamped == RADIX_DECIMAL) && in_item_i.value[VALUE_WIDTH-1];
  end

  // One restoring division step: bring in the next dividend bit and subtract
  // the radix where it fits; the quotient bit shifts in from the right.
  assign trial = {rem_q, quot_q[VALUE_WIDTH-1]};

  always_comb begin
    pc_d        = pc_q;
    quot_d      = quot_q;
    rem_d       = rem_q;
    radix_d     = radix_q;
    bit_cnt_d   = bit_cnt_q;
    ndig_d      = ndig_q;
    neg_d       = neg_q;
    out_item_d  = out_item_q;
    out_valid_d = out_valid_q && out_stall_i;
    mem_we      = 1'b0;
    mem_re      = 1'b0;
    mem_waddr   = ndig_q[DIG_IDX_W-1:0];
    mem_raddr   = ndig_dec[DIG_IDX_W-1:0];

    if (wait_ok) begin
      pc_d = br_ok ? uw.target : pc_q + PC_W'(1);
      unique case (uw.op)
        OP_NOP: begin
        end
        OP_LOAD: begin
          radix_d = radix_clamped;
          neg_d   = load_neg;
          quot_d  = load_neg ? VALUE_WIDTH'(-in_item_i.value)
                             : VALUE_WIDTH'(in_item_i.value);
          ndig_d  = '0;
        end
        OP_CLR_REM: begin
          rem_d     = '0;
          bit_cnt_d = '0;
        end
        OP_DIV_BIT: begin
          bit_cnt_d = bit_cnt_q + BIT_CNT_W'(1);
          if (trial >= {1'b0, radix_q}) begin
            rem_d  = RADIX_WIDTH'(trial - {1'b0, radix_q});
            quot_d = {quot_q[VALUE_WIDTH-2:0], 1'b1};
          end else begin
            rem_d  = trial[RADIX_WIDTH-1:0];
            quot_d = {quot_q[VALUE_WIDTH-2:0], 1'b0};
          end
        end
        OP_STORE: begin
          mem_we = 1'b1;
          ndig_d = ndig_q + DIG_CNT_W'(1);
        end
        OP_SIGN: begin
          if (neg_q) begin
            out_valid_d          = 1'b1;
            out_item_d.character = CHAR_MINUS;
            out_item_d.last      = 1'b0;
          end
        end
        OP_READ: begin
          mem_re = 1'b1;
          ndig_d = ndig_dec;
        end
        OP_EMIT: begin
          out_valid_d          = 1'b1;
          out_item_d.character = digit_char(rd_digit_q);
          out_item_d.last      = (ndig_q == '0);
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q        <= PC_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      pc_q        <= pc_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quot_q     <= quot_d;
    rem_q      <= rem_d;
    radix_q    <= radix_d;
    bit_cnt_q  <= bit_cnt_d;
    ndig_q     <= ndig_d;
    neg_q      <= neg_d;
    out_item_q <= out_item_d;
  end

  // Digits are produced least significant first and read back in reverse.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      dig_mem[mem_waddr] <= rem_q;
    end
    if (mem_re) begin
      rd_digit_q <= dig_mem[mem_raddr];
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

endmodule

@@ tb/tb_integer_to_radix_string.sv @@
// Self-checking testbench for integer_to_radix_string: a clocked driver and monitor,
// a behavioural model of the conversion, and random idling on both channels.
// Depends on itors_pkg and the integer_to_radix_string RTL.
`timescale 1ns / 1ps

module tb_integer_to_radix_string;
  import itors_pkg::*;

  localparam int unsigned RANDOM_ITEMS = 250;
  localparam int unsigned HOLD_AT      = 30;
  localparam int unsigned HOLD_CYCLES  = 400;
  localparam int unsigned TAIL_CYCLES  = 60;
  // Worst case per item: 32 binary digits through the divider, each character
  // behind a long receiver stall, plus a long sender gap; then taken thrice.
  localparam int unsigned CYCLE_LIMIT  =
      3 * ((RANDOM_ITEMS + 30) * (1200 + 32 * 45 + 45) + HOLD_CYCLES);

  typedef struct {
    in_item_t    item;
    int unsigned gap;
    bit          drain;
  } conversion_t;

  logic      clk_i       = 1'b0;
  logic      rst_ni      = 1'b0;
  logic      in_valid_i  = 1'b0;
  logic      in_stall_o;
  in_item_t  in_item_i   = '0;
  logic      out_valid_o;
  logic      out_stall_i = 1'b0;
  out_item_t out_item_o;

  conversion_t conversions_pending[$];
  out_item_t   expected_chars[$];

  int unsigned items_in       = 0;
  int unsigned chars_expected = 0;
  int unsigned chars_seen     = 0;
  int unsigned hold_left      = 0;
  int unsigned cycle_count    = 0;
  int unsigned error_count    = 0;

  integer_to_radix_string dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Works out the text of one number and queues its characters; returns how
  // many there are.
  function automatic int unsigned spell_number(in_item_t req);
    logic [RADIX_WIDTH-1:0] base;
    logic [VALUE_WIDTH-1:0] mag;
    logic [VALUE_WIDTH-1:0] digit;
    logic [CHAR_WIDTH-1:0]  text[$];
    bit                     negative;
    int unsigned            count;
    base = req.radix;
    if (base < RADIX_MIN) base = RADIX_MIN;
    if (base > RADIX_MAX) base = RADIX_MAX;
    mag = req.value;
    negative = (base == RADIX_DECIMAL) && mag[VALUE_WIDTH-1];
    // The most negative value negates onto itself, which as an unsigned
    // magnitude is exactly right.
    if (negative) mag = ~mag + 1'b1;
    do begin
      digit = mag % base;
      if (digit < 10) begin
        text.push_front("0" + digit[CHAR_WIDTH-1:0]);
      end else begin
        text.push_front("A" + digit[CHAR_WIDTH-1:0] - 8'd10);
      end
      mag = mag / base;
    end while (mag != 0);
    count = 0;
    if (negative) begin
      expected_chars.push_back('{character: CHAR_MINUS, last: 1'b0});
      count++;
    end
    foreach (text[i]) begin
      expected_chars.push_back('{character: text[i], last: (i == text.size() - 1)});
      count++;
    end
    return count;
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 88) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic in_item_t random_number();
    in_item_t    req;
    int unsigned r;
    r = $urandom_range(0, 9);
    case (r) inside
      [0:3]: req.value = $urandom;
      [4:5]: req.value = $urandom_range(0, 999);
      6:     req.value = -$signed(VALUE_WIDTH'($urandom_range(1, 999)));
      7: begin
        case ($urandom_range(0, 3))
          0:       req.value = 32'h8000_0000;
          1:       req.value = 32'h7FFF_FFFF;
          2:       req.value = 32'hFFFF_FFFF;
          default: req.value = '0;
        endcase
      end
      default: req.value = $urandom >> $urandom_range(0, 31);
    endcase
    r = $urandom_range(0, 19);
    if (r < 13) begin
      req.radix = RADIX_WIDTH'($urandom_range(2, 36));
    end else if (r < 16) begin
      req.radix = RADIX_DECIMAL;
    end else if (r < 18) begin
      req.radix = RADIX_WIDTH'($urandom_range(0, 1));
    end else begin
      req.radix = RADIX_WIDTH'($urandom_range(37, 63));
    end
    return req;
  endfunction

  task automatic add_conversion(logic [VALUE_WIDTH-1:0] value, logic [RADIX_WIDTH-1:0] radix,
                                int unsigned gap, bit drain);
    conversion_t c;
    c.item.value = value;
    c.item.radix = radix;
    c.gap = gap;
    c.drain = drain;
    conversions_pending.push_back(c);
  endtask

  // Driver: offers the pending items in order, holding each until it is taken.
  always @(posedge clk_i) begin : drive_input
    bit          taken;
    int unsigned n;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      taken = in_valid_i && !in_stall_o;
      if (taken) begin
        n = spell_number(in_item_i);
        chars_expected <= chars_expected + n;
        items_in <= items_in + 1;
      end
      if (!in_valid_i || taken) begin
        if (conversions_pending.size() == 0) begin
          in_valid_i <= 1'b0;
        end else if (conversions_pending[0].gap > 0) begin
          conversions_pending[0].gap--;
          in_valid_i <= 1'b0;
        end else if (conversions_pending[0].drain &&
                     (taken || chars_seen != chars_expected)) begin
          in_valid_i <= 1'b0;
        end else begin
          in_item_i <= conversions_pending[0].item;
          in_valid_i <= 1'b1;
          void'(conversions_pending.pop_front());
        end
      end
    end
  end

  // Receiver hold-off: once, a long stretch with the output stalled while the
  // sender keeps offering items.
  always @(posedge clk_i) begin : hold_receiver
    bit hold_done;
    if (!rst_ni) begin
      hold_left <= 0;
      hold_done = 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (!hold_done && items_in == HOLD_AT) begin
      hold_left <= HOLD_CYCLES;
      hold_done = 1'b1;
    end
  end

  // Monitor: checks each accepted character and drives the output stall.
  always @(posedge clk_i) begin : watch_output
    out_item_t   want;
    int unsigned run_left;
    int unsigned r;
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      run_left = 0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        chars_seen <= chars_seen + 1;
        if (expected_chars.size() == 0) begin
          $error("unexpected character 0x%02h (last %0b)", out_item_o.character,
                 out_item_o.last);
          error_count++;
        end else begin
          want = expected_chars.pop_front();
          if (out_item_o.character !== want.character) begin
            $error("character: expected 0x%02h, got 0x%02h", want.character,
                   out_item_o.character);
            error_count++;
          end
          if (out_item_o.last !== want.last) begin
            $error("last: expected %0b, got %0b", want.last, out_item_o.last);
            error_count++;
          end
        end
      end
      if (hold_left != 0) begin
        out_stall_i <= 1'b1;
        run_left = 0;
      end else if (run_left > 0) begin
        run_left--;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 55) begin
          out_stall_i <= 1'b0;
          run_left = $urandom_range(0, 7);
        end else if (r < 65) begin
          out_stall_i <= 1'b0;
          run_left = $urandom_range(30, 150);
        end else if (r < 95) begin
          out_stall_i <= 1'b1;
          run_left = $urandom_range(0, 2);
        end else begin
          out_stall_i <= 1'b1;
          run_left = $urandom_range(15, 40);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    int unsigned total;
    // Directed part: field extremes, clamped radices and the sign cases.
    add_conversion(32'h0000_0000, 6'd10, 0, 1'b0);
    add_conversion(32'h0000_0000, 6'd2,  0, 1'b0);
    add_conversion(32'hFFFF_FFFF, 6'd10, 0, 1'b0);
    add_conversion(32'hFFFF_FFFF, 6'd2,  0, 1'b0);
    add_conversion(32'hFFFF_FFFF, 6'd16, 0, 1'b0);
    add_conversion(32'hFFFF_FFFF, 6'd9,  2, 1'b0);
    add_conversion(32'h7FFF_FFFF, 6'd10, 0, 1'b0);
    add_conversion(32'h8000_0000, 6'd10, 0, 1'b0);
    add_conversion(32'h8000_0000, 6'd2,  0, 1'b0);
    add_conversion(32'h8000_0000, 6'd8,  0, 1'b0);
    add_conversion(32'h0000_0005, 6'd0,  0, 1'b0);
    add_conversion(32'h0000_0006, 6'd1,  0, 1'b0);
    add_conversion(32'h0000_0023, 6'd37, 0, 1'b0);
    add_conversion(32'hFFFF_FFFF, 6'd63, 0, 1'b0);
    add_conversion(32'h0000_0023, 6'd36, 0, 1'b0);
    add_conversion(32'hFFFF_FFFF, 6'd36, 0, 1'b0);
    add_conversion(32'h0000_000A, 6'd11, 0, 1'b0);
    add_conversion(32'h0000_0009, 6'd10, 0, 1'b0);
    add_conversion(32'hFFFF_FFFF, 6'd3,  0, 1'b0);
    add_conversion(32'd123456789, 6'd10, 0, 1'b0);
    add_conversion(-32'sd10,      6'd10, 0, 1'b0);
    add_conversion(32'h0000_0001, 6'd10, 0, 1'b0);
    // Random part; a few items wait for the block to drain first, and one
    // stretch has no sender gaps at all.
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      conversion_t c;
      c.item = random_number();
      c.gap = (i >= 100 && i < 140) ? 0 : pick_gap();
      c.drain = (i % 60 == 0);
      conversions_pending.push_back(c);
    end
    total = conversions_pending.size();

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (items_in != total) @(negedge clk_i);
    while (chars_seen != chars_expected) @(negedge clk_i);
    repeat (TAIL_CYCLES) @(negedge clk_i);
    if (error_count == 0 && expected_chars.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

@@ files.f @@
hw/rtl/itors_pkg.sv
hw/rtl/integer_to_radix_string.sv
tb/tb_integer_to_radix_string.sv
